/* design/mrs_pkg.sv */
// shared types, constants and codes of the modbus rtu register slave
package mrs_pkg;

  localparam int unsigned REG_DEPTH_DEF = 16;
  localparam int unsigned FRAME_DEPTH   = 41;
  localparam int unsigned MAX_QTY       = 16;

  localparam logic [7:0]  FC_READ        = 8'h03;
  localparam logic [7:0]  FC_WRITE       = 8'h10;
  localparam logic [7:0]  SLAVE_ADDR_RST = 8'h05;
  localparam logic [15:0] CRC_PRESET     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  localparam logic [5:0] READ_LEN      = 6'd8;
  localparam logic [5:0] WRITE_LEN_BASE = 6'd9;
  localparam logic [5:0] DATA_OFS      = 6'd7;
  localparam logic [5:0] ECHO_LEN      = 6'd6;
  localparam logic [5:0] READ_HDR_LEN  = 6'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } mrs_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } mrs_out_t;

  typedef struct packed {
    logic rx_accept;
    logic cmt_init;
    logic tx_init;
    logic cnt_inc;
    logic rd_en;
    logic hi_ld;
    logic reg_we;
    logic ld_out;
  } mrs_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic req_ok;
    logic is_read;
    logic cmt_done;
    logic tx_last;
    logic out_free;
  } mrs_sts_t;

endpackage

/* design/mrs_datapath.sv */
// frame store, crc, register file and reply byte path
module mrs_datapath import mrs_pkg::*; #(
  parameter int unsigned RegDepth = REG_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mrs_in_t    in_data_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output mrs_out_t   out_data_o,
  input  mrs_cmd_t   cmd_i,
  output mrs_sts_t   sts_o
);

  localparam int unsigned RegIdxW = (RegDepth > 1) ? $clog2(RegDepth) : 1;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  logic [7:0]  slave_q;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [5:0]  len_q, len_d;
  logic        closed_q, closed_d;
  logic [7:0]  hdr_q [6];
  logic [7:0]  mem_q [FRAME_DEPTH];
  logic [7:0]  rd_data_q, hi_q;
  logic [15:0] regs_q [RegDepth];
  logic [RegIdxW-1:0] widx_q, ridx_q;
  logic [5:0]  cnt_q;
  logic [15:0] txcrc_q;
  logic        out_valid_q;
  mrs_out_t    out_q;

  // receive side
  logic [7:0]  b;
  logic [5:0]  eff_pos, eff_len;
  logic [15:0] eff_crc, qty_new;
  logic        eff_closed, store_en, frame_end;

  assign b          = in_data_i.rx_byte;
  assign eff_pos    = in_data_i.frame_start ? 6'd0 : pos_q;
  assign eff_len    = in_data_i.frame_start ? 6'd0 : len_q;
  assign eff_crc    = in_data_i.frame_start ? CRC_PRESET : crc_q;
  assign eff_closed = in_data_i.frame_start ? 1'b0 : closed_q;
  assign qty_new    = {hdr_q[4], b};

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    len_d     = len_q;
    closed_d  = closed_q;
    store_en  = 1'b0;
    frame_end = 1'b0;
    if (cmd_i.rx_accept) begin
      pos_d    = eff_pos;
      crc_d    = eff_crc;
      len_d    = eff_len;
      closed_d = eff_closed;
      if (!eff_closed) begin
        if (eff_pos >= 6'(FRAME_DEPTH)) begin
          closed_d = 1'b1;
        end else begin
          store_en = 1'b1;
          crc_d    = crc_step(eff_crc, b);
          pos_d    = eff_pos + 6'd1;
          if (pos_d == 6'd2) begin
            if (b == FC_READ) len_d = READ_LEN;
            else if (b != FC_WRITE) closed_d = 1'b1;
          end
          if (pos_d == 6'd6 && hdr_q[1] == FC_WRITE) begin
            if (qty_new == 16'd0 || qty_new > 16'(MAX_QTY)) closed_d = 1'b1;
            else len_d = WRITE_LEN_BASE + {qty_new[4:0], 1'b0};
          end
          if (!closed_d && len_d != 6'd0 && pos_d == len_d) begin
            closed_d  = 1'b1;
            frame_end = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 6'd0;
      crc_q    <= CRC_PRESET;
      len_q    <= 6'd0;
      closed_q <= 1'b0;
      slave_q  <= SLAVE_ADDR_RST;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      closed_q <= closed_d;
      if (cfg_we_i) slave_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en && eff_pos < 6'd6) hdr_q[eff_pos[2:0]] <= b;
  end

  // frame store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (store_en) mem_q[eff_pos] <= b;
    if (cmd_i.rd_en) rd_data_q <= mem_q[DATA_OFS + cnt_q];
    if (cmd_i.hi_ld) hi_q <= rd_data_q;
  end

  // request decode
  logic [15:0] req_start, req_qty;
  logic [16:0] range_end;
  logic        is_read;
  logic [5:0]  msg_len;

  assign req_start = {hdr_q[2], hdr_q[3]};
  assign req_qty   = {hdr_q[4], hdr_q[5]};
  assign range_end = {1'b0, req_start} + {1'b0, req_qty};
  assign is_read   = hdr_q[1] == FC_READ;
  assign msg_len   = is_read ? (READ_HDR_LEN + {req_qty[4:0], 1'b0}) : ECHO_LEN;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(RegDepth); i++) regs_q[i] <= 16'h0000;
    end else if (cmd_i.reg_we) begin
      regs_q[widx_q] <= {hi_q, rd_data_q};
    end
  end

  // reply byte select
  logic [7:0]  tx_b;
  logic        msg_byte;
  logic [15:0] reg_rd;

  assign reg_rd = regs_q[ridx_q];

  always_comb begin
    tx_b     = 8'h00;
    msg_byte = 1'b0;
    priority if (cnt_q == msg_len) begin
      tx_b = txcrc_q[7:0];
    end else if (cnt_q == msg_len + 6'd1) begin
      tx_b = txcrc_q[15:8];
    end else begin
      msg_byte = 1'b1;
      if (is_read) begin
        priority if (cnt_q == 6'd0) tx_b = hdr_q[0];
        else if (cnt_q == 6'd1)     tx_b = FC_READ;
        else if (cnt_q == 6'd2)     tx_b = {req_qty[6:0], 1'b0};
        else if (cnt_q[0])          tx_b = reg_rd[15:8];
        else                        tx_b = reg_rd[7:0];
      end else begin
        unique case (cnt_q[2:0])
          3'd0:    tx_b = hdr_q[0];
          3'd1:    tx_b = hdr_q[1];
          3'd2:    tx_b = hdr_q[2];
          3'd3:    tx_b = hdr_q[3];
          3'd4:    tx_b = hdr_q[4];
          3'd5:    tx_b = hdr_q[5];
          default: tx_b = 8'h00;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 6'd0;
      widx_q      <= '0;
      ridx_q      <= '0;
      txcrc_q     <= CRC_PRESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cmt_init || cmd_i.tx_init) cnt_q <= 6'd0;
      else if (cmd_i.cnt_inc)              cnt_q <= cnt_q + 6'd1;
      if (cmd_i.cmt_init)    widx_q <= req_start[RegIdxW-1:0];
      else if (cmd_i.reg_we) widx_q <= widx_q + RegIdxW'(1);
      if (cmd_i.tx_init) begin
        ridx_q  <= req_start[RegIdxW-1:0];
        txcrc_q <= CRC_PRESET;
      end else if (cmd_i.ld_out && msg_byte) begin
        txcrc_q <= crc_step(txcrc_q, tx_b);
        // step to next register after its low byte
        if (is_read && cnt_q > 6'd3 && !cnt_q[0]) ridx_q <= ridx_q + RegIdxW'(1);
      end
      if (cmd_i.ld_out)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_q.tx_byte   <= tx_b;
      out_q.last_byte <= (cnt_q == msg_len + 6'd1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.frame_end = frame_end;
  assign sts_o.req_ok    = hdr_q[0] == slave_q && crc_q == 16'h0000 && req_qty != 16'd0 &&
                           req_qty <= 16'(MAX_QTY) && range_end <= 17'(RegDepth);
  assign sts_o.is_read   = is_read;
  assign sts_o.cmt_done  = cnt_q == {req_qty[4:0], 1'b0};
  assign sts_o.tx_last   = cnt_q == msg_len + 6'd1;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("reply byte overwritten before it was taken");

  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reg_we |-> 32'(widx_q) < RegDepth)
    else $error("register write outside register file");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> closed_q)
    else $error("frame not closed after its last byte");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_out && sts_o.tx_last |=> out_valid_q && out_q.last_byte)
    else $error("final reply byte lost its last flag");

endmodule

/* design/mrs_ctrl.sv */
// controller state machine of the register slave
module mrs_ctrl import mrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mrs_sts_t sts_i,
  output mrs_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_CMT_HI = 6'b000100,
    S_CMT_LO = 6'b001000,
    S_CMT_WR = 6'b010000,
    S_TX     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.rx_accept = in_valid_i && (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.rx_accept && sts_i.frame_end) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!sts_i.req_ok) begin
          state_d = S_IDLE;
        end else if (sts_i.is_read) begin
          cmd_o.tx_init = 1'b1;
          state_d       = S_TX;
        end else begin
          cmd_o.cmt_init = 1'b1;
          state_d        = S_CMT_HI;
        end
      end
      S_CMT_HI: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_CMT_LO;
      end
      S_CMT_LO: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.hi_ld   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_CMT_WR;
      end
      S_CMT_WR: begin
        cmd_o.reg_we = 1'b1;
        if (sts_i.cmt_done) begin
          cmd_o.tx_init = 1'b1;
          state_d       = S_TX;
        end else begin
          state_d = S_CMT_HI;
        end
      end
      S_TX: begin
        if (sts_i.out_free) begin
          cmd_o.ld_out  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.tx_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

/* design/modbus_rtu_register_slave_top.sv */
// top level of the modbus rtu holding-register slave (functions 0x03 and 0x10)
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   mrs_in_t  {rx_byte, frame_start}
//   out      source     out_valid_o/out_ready_i mrs_out_t {tx_byte, last_byte}
//   cfg      sink       cfg_we_i                cfg_wdata_i, slave address
//
// a received byte that does not end a frame leaves the controller idle
// the byte that ends a frame is followed by a request check
// a good write then commits its registers one by one through the frame store read port
// the reply leaves the output register one byte per cycle while out_ready_i is high:
// 5 + 2*count bytes for a read, 8 for a write echo; otherwise it stalls, input waits
// reset clears control state and the register file flip-flops at once, no clearing pass
module modbus_rtu_register_slave_top import mrs_pkg::*; #(
  parameter int unsigned RegDepth = REG_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mrs_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output mrs_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  // command and status between controller and datapath
  mrs_cmd_t cmd;
  mrs_sts_t sts;

  // sequencing: receive, check, commit, reply
  mrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // frame store, crc, register file and reply output register
  mrs_datapath #(
    .RegDepth (RegDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
